@@ src/lkvc_pkg.sv @@
// lkvc_pkg: shared types and constants for the lru key-value cache
// used by lkvc_cell and lru_key_value_cache; no dependencies
`default_nettype none

package lkvc_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int CAP_W     = 5;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic shift;
		logic valid;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ src/lkvc_cell.sv @@
// lkvc_cell: one recency slot holding a key and a value, compares its key
// and loads from its more recent neighbor on shift; depends on lkvc_pkg
`default_nettype none

module lkvc_cell
	import lkvc_pkg::*;
(
	input  wire logic             clk,
	input  wire cell_ctl_t        ctl,
	input  wire logic [KEY_W-1:0] cmp_key,
	input  wire logic [KEY_W-1:0] prev_key,
	input  wire logic [VAL_W-1:0] prev_value,
	output logic      [KEY_W-1:0] key,
	output logic      [VAL_W-1:0] value,
	output logic                  match
);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign match = ctl.valid && (key_q == cmp_key);

endmodule

`default_nettype wire

@@ src/lru_key_value_cache.sv @@
// lru_key_value_cache: top level, sequencer, use count and result register
// over a row of lkvc_cell slots ordered most recent first; depends on lkvc_pkg, lkvc_cell
//
// Usage:
//  - input channel (in_valid/in_ready) carries action, lookup_key, store_value;
//    action get looks up the key, put stores key and value
//  - output channel (out_valid/out_ready) returns hit and read_value, one
//    result per input transfer, in order
//  - cfg_wr_en/cfg_wr_data write the capacity (0 acts as 1, above DEPTH acts
//    as DEPTH); lowering it drops the least recent entries at once
//  - an item goes through the transfer, then the update state in which every slot
//    compares its key against the item and, on a hit or a put, the row shifts by one
//    toward the least recent end up to the hit slot or the fill point
//  - out_valid is registered from the update; a new input transfer is taken only
//    after the update of the previous item
//  - a waiting result does not block the next input transfer; the update
//    cycle of that item waits until the result register is free
//  - reset empties the cache and sets capacity to 16; no clearing pass
`default_nettype none

module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    action,
	input  wire logic signed [KEY_W-1:0] lookup_key,
	input  wire logic signed [VAL_W-1:0] store_value,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         hit,
	output logic signed      [VAL_W-1:0] read_value,
	input  wire logic                    cfg_wr_en,
	input  wire logic        [CAP_W-1:0] cfg_wr_data
);

	localparam int UW = $clog2(DEPTH + 1);
	localparam int CW = (UW > CAP_W) ? UW : CAP_W;

	state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	logic [UW-1:0]    used_q;

	logic             act_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] val_s1;

	logic             out_valid_q;
	logic             hit_q;
	logic [VAL_W-1:0] read_value_q;

	logic             accept;
	logic             do_update;

	logic [KEY_W-1:0] cell_key   [DEPTH];
	logic [VAL_W-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0] match;
	logic [DEPTH:0]   above;
	cell_ctl_t        ctl        [DEPTH];

	logic             any_hit;
	logic [VAL_W-1:0] hit_value;
	logic [VAL_W-1:0] head_value;
	logic [UW-1:0]    eff_cap;
	logic [UW-1:0]    eff_cap_new;
	logic [UW-1:0]    fill_n;
	logic             is_put;

	function automatic logic [UW-1:0] clamp_cap(input logic [CAP_W-1:0] c);
		logic [CW-1:0] ce;
		logic [CW-1:0] r;
		ce = CW'(c);
		if (ce == '0)
			r = CW'(1);
		else if (ce > CW'(DEPTH))
			r = CW'(DEPTH);
		else
			r = ce;
		return UW'(r);
	endfunction

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_UPDATE;
			ST_UPDATE: if (do_update) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		do_update = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
	end

	assign accept = in_valid && in_ready;
	assign is_put = (act_s1 == ACT_PUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= action;
			key_s1 <= lookup_key;
			val_s1 <= store_value;
		end
	end

	// lookup across the row
	assign eff_cap     = clamp_cap(cap_q);
	assign eff_cap_new = clamp_cap(cfg_wr_data);
	assign fill_n      = (used_q >= eff_cap) ? eff_cap - UW'(1) : used_q;
	assign any_hit     = |match;
	assign head_value  = is_put ? val_s1 : hit_value;

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_value = hit_value | (match[i] ? cell_value[i] : '0);
		end
	end

	// a slot shifts when no more recent slot holds the key (hit), or when
	// it lies at or before the fill point (put miss)
	assign above[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_row
		assign above[i+1] = above[i] | match[i];

		always_comb begin
			ctl[i].valid = (UW'(i) < used_q);
			if (!do_update)
				ctl[i].shift = 1'b0;
			else if (any_hit)
				ctl[i].shift = !above[i];
			else
				ctl[i].shift = is_put && (UW'(i) <= fill_n);
		end

		if (i == 0) begin : g_head
			lkvc_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[i]),
				.cmp_key    (key_s1),
				.prev_key   (key_s1),
				.prev_value (head_value),
				.key        (cell_key[i]),
				.value      (cell_value[i]),
				.match      (match[i])
			);
		end else begin : g_tail
			lkvc_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[i]),
				.cmp_key    (key_s1),
				.prev_key   (cell_key[i-1]),
				.prev_value (cell_value[i-1]),
				.key        (cell_key[i]),
				.value      (cell_value[i]),
				.match      (match[i])
			);
		end
	end

	// capacity and use count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			used_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
				if (used_q > eff_cap_new)
					used_q <= eff_cap_new;
			end else if (do_update && is_put && !any_hit) begin
				used_q <= fill_n + UW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (do_update)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_update) begin
			hit_q <= any_hit;
			if (is_put)
				read_value_q <= PUT_VALUE;
			else if (any_hit)
				read_value_q <= hit_value;
			else
				read_value_q <= MISS_VALUE;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	// keys held in valid slots are distinct
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one slot matches the key");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= eff_cap)
		else $error("use count above effective capacity");

	a_update_result: assert property (@(posedge clk) disable iff (!arst_n)
		do_update |=> out_valid_q && state_q == ST_IDLE)
		else $error("update did not produce a result");

	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_UPDATE)
		else $error("transfer not followed by update");

	a_no_shift_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!do_update |-> !ctl[0].shift)
		else $error("row shifted outside update");

endmodule

`default_nettype wire

@@ tb/lru_key_value_cache_tb.sv @@
`timescale 1ns / 1ps
// lru_key_value_cache_tb: self-checking bench for the lru key-value cache, directed table
// then random get/put traffic over several capacities, checked against a local lru model
// depends on lkvc_pkg and lru_key_value_cache

module lru_key_value_cache_tb;
	import lkvc_pkg::*;

	localparam int SLOTS = DEPTH_DEF;
	localparam int PHASES = 15;
	localparam int ITEMS_PER_PHASE = 87;
	localparam int POOL_MAX = SLOTS + 4;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value;
	} cache_result_t;

	typedef enum logic {
		ROW_ACCESS,
		ROW_CAPACITY
	} row_kind_t;

	// capacity rows carry the register value in val
	typedef struct packed {
		row_kind_t        kind;
		logic             act;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		logic             typed;
		logic             exp_hit;
		logic [VAL_W-1:0] exp_value;
	} stim_row_t;

	localparam int DIRECTED_LEN = 25;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
		'{ROW_ACCESS,   ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h8000_0000, 32'hdead_beef, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, PUT_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, PUT_VALUE},
		// hit that returns the same bits as a miss
		'{ROW_ACCESS,   ACT_GET, 32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h0000_0001, 32'hffff_ffff, 1'b1, 1'b0, MISS_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h0000_0001, 32'h5555_5555, 1'b1, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h0000_0002, 32'haaaa_aaaa, 1'b1, 1'b0, PUT_VALUE},
		// shrink below use, oldest entries go
		'{ROW_CAPACITY, ACT_GET, 32'h0000_0000, 32'd2,         1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h0000_0003, 32'h1234_5678, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE},
		// zero acts as one
		'{ROW_CAPACITY, ACT_GET, 32'h0000_0000, 32'd0,         1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h0000_0004, 32'h0000_0007, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE},
		// above depth acts as depth
		'{ROW_CAPACITY, ACT_GET, 32'h0000_0000, 32'd31,        1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h0000_0005, 32'h0000_0009, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h0000_0004, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, PUT_VALUE},
		'{ROW_CAPACITY, ACT_GET, 32'h0000_0000, 32'd17,        1'b0, 1'b0, PUT_VALUE},
		'{ROW_ACCESS,   ACT_PUT, 32'h0000_0006, 32'h0000_0001, 1'b0, 1'b0, PUT_VALUE}
	};

	localparam logic [CAP_W-1:0] CAP_PLAN [PHASES] = '{
		5'd4, 5'd1, 5'd16, 5'd2, 5'd9, 5'd0, 5'd31, 5'd8, 5'd3, 5'd16, 5'd6, 5'd20, 5'd1,
		5'd12, 5'd5
	};

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    action;
	logic signed [KEY_W-1:0] lookup_key;
	logic signed [VAL_W-1:0] store_value;
	logic                    out_valid;
	logic                    out_ready;
	logic                    hit;
	logic signed [VAL_W-1:0] read_value;
	logic                    cfg_wr_en;
	logic        [CAP_W-1:0] cfg_wr_data;

	lru_key_value_cache uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.lookup_key (lookup_key),
		.store_value(store_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_value (read_value),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// local lru model: slot 0 most recent
	logic [KEY_W-1:0] slot_key [SLOTS];
	logic [VAL_W-1:0] slot_val [SLOTS];
	int unsigned      used_slots;
	logic [CAP_W-1:0] capacity_reg;

	cache_result_t expected_results [$];
	int            mismatch_count;
	int            tx_idle_pct;
	int            rx_idle_pct;

	function automatic int unsigned effective_capacity();
		if (capacity_reg < 1)
			return 1;
		if (capacity_reg > SLOTS)
			return SLOTS;
		return capacity_reg;
	endfunction

	function automatic void move_to_front(int unsigned pos);
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		int unsigned      i;
		k = slot_key[pos];
		v = slot_val[pos];
		for (i = pos; i > 0; i--) begin
			slot_key[i] = slot_key[i-1];
			slot_val[i] = slot_val[i-1];
		end
		slot_key[0] = k;
		slot_val[0] = v;
	endfunction

	function automatic cache_result_t predict_access(logic act, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		cache_result_t r;
		int unsigned   i;
		int unsigned   pos;
		int unsigned   n;
		bit            found;
		found = 0;
		pos = 0;
		for (i = 0; i < used_slots; i++) begin
			if (!found && slot_key[i] == k) begin
				found = 1;
				pos = i;
			end
		end
		if (act == ACT_GET) begin
			if (found) begin
				move_to_front(pos);
				r.hit = 1'b1;
				r.value = slot_val[0];
			end else begin
				r.hit = 1'b0;
				r.value = MISS_VALUE;
			end
			return r;
		end
		r.value = PUT_VALUE;
		if (found) begin
			slot_val[pos] = v;
			move_to_front(pos);
			r.hit = 1'b1;
			return r;
		end
		n = used_slots;
		if (n >= effective_capacity())
			n = effective_capacity() - 1;
		for (i = n; i > 0; i--) begin
			slot_key[i] = slot_key[i-1];
			slot_val[i] = slot_val[i-1];
		end
		slot_key[0] = k;
		slot_val[0] = v;
		used_slots = n + 1;
		r.hit = 1'b0;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle_pct);

	// result checker
	always @(posedge clk) begin
		cache_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result hit=%0b read_value=%h", $time, hit,
					read_value);
				mismatch_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (hit !== exp_r.hit) begin
					$display("%0t: hit expected %0b got %0b", $time, exp_r.hit, hit);
					mismatch_count++;
				end
				if (read_value !== exp_r.value) begin
					$display("%0t: read_value expected %h got %h", $time, exp_r.value,
						read_value);
					mismatch_count++;
				end
			end
		end
	end

	// call right after a rising edge; returns at the edge of the transfer
	task automatic send_request(logic act, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			logic typed, cache_result_t typed_r);
		cache_result_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		lookup_key <= k;
		store_value <= v;
		do @(posedge clk); while (!in_ready);
		r = predict_access(act, k, v);
		expected_results.push_back(typed ? typed_r : r);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] c);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity_reg = c;
		if (used_slots > effective_capacity())
			used_slots = effective_capacity();
	endtask

	initial begin
		logic [KEY_W-1:0] key_pool [POOL_MAX];
		logic [KEY_W-1:0] k;
		cache_result_t    typed_r;
		int               ph;
		int               n;
		int               pool_size;

		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_GET;
		lookup_key = '0;
		store_value = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		mismatch_count = 0;
		tx_idle_pct = 34;
		rx_idle_pct = 72;
		used_slots = 0;
		capacity_reg = CAP_RESET;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_LEN; n++) begin
			if (DIRECTED_ROWS[n].kind == ROW_CAPACITY) begin
				write_capacity(DIRECTED_ROWS[n].val[CAP_W-1:0]);
			end else begin
				typed_r.hit = DIRECTED_ROWS[n].exp_hit;
				typed_r.value = DIRECTED_ROWS[n].exp_value;
				send_request(DIRECTED_ROWS[n].act, DIRECTED_ROWS[n].key,
					DIRECTED_ROWS[n].val, DIRECTED_ROWS[n].typed, typed_r);
			end
		end

		typed_r = '0;
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph / 5)
				0: begin
					tx_idle_pct = 34;
					rx_idle_pct = 72;
				end
				1: begin
					tx_idle_pct = 72;
					rx_idle_pct = 34;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			write_capacity(CAP_PLAN[ph]);
			// a pool a little larger than capacity gives hits and evictions alike
			pool_size = effective_capacity() + $urandom_range(4, 1);
			for (n = 0; n < pool_size; n++)
				key_pool[n] = $urandom;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(9) == 0)
					k = $urandom;
				else
					k = key_pool[$urandom_range(pool_size - 1)];
				send_request(1'($urandom_range(1)), k, $urandom, 1'b0, typed_r);
			end
		end

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ sim.f @@
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache.sv
tb/lru_key_value_cache_tb.sv
